[hdl/delay_aimd_congestion_window_unit_assert.svh]
// Assertion macros shared by the checker of the congestion window unit.
`ifndef DELAY_AIMD_CONGESTION_WINDOW_UNIT_ASSERT_SVH
`define DELAY_AIMD_CONGESTION_WINDOW_UNIT_ASSERT_SVH

// Property checked on every rising edge of clk, suspended while reset is applied.
`define DAW_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Property checked on every rising edge of clk, reset included.
`define DAW_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/daw_pkg.sv]
// Shared types and constants of the delay-based AIMD congestion window unit.
package daw_pkg;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_SMOOTHING_GAIN  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DECREASE_FACTOR = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INCREASE_STEP   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_GAIN    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_INITIAL_WINDOW  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_INITIAL_RTT     = 3'd5;

	// Register values after reset.
	localparam logic [15:0] RST_SMOOTHING_GAIN  = 16'd52429;
	localparam logic [15:0] RST_DECREASE_FACTOR = 16'd32768;
	localparam logic [15:0] RST_INCREASE_STEP   = 16'd256;
	localparam logic [15:0] RST_TIMEOUT_GAIN    = 16'd512;
	localparam logic [15:0] RST_INITIAL_WINDOW  = 16'd10;
	localparam logic [15:0] RST_INITIAL_RTT     = 16'd100;

	// One datagram in Q16.16.
	localparam logic [31:0] WINDOW_ONE = 32'h0001_0000;
	// Quotient bits produced by the serial divider.
	localparam int DIV_STEPS = 40;
	localparam int DIV_CNT_W = 6;

	// Datapath commands.
	localparam int CMD_W = 5;
	typedef logic [CMD_W-1:0] cmd_t;
	localparam cmd_t CMD_NONE       = 5'd0;
	localparam cmd_t CMD_LOAD       = 5'd1;
	localparam cmd_t CMD_TO_MUL     = 5'd2;
	localparam cmd_t CMD_TO_SET     = 5'd3;
	localparam cmd_t CMD_SCAN_DUP   = 5'd4;
	localparam cmd_t CMD_INSERT     = 5'd5;
	localparam cmd_t CMD_SCAN_PURGE = 5'd6;
	localparam cmd_t CMD_CUT_MUL    = 5'd7;
	localparam cmd_t CMD_CUT_SET    = 5'd8;
	localparam cmd_t CMD_EST_MUL    = 5'd9;
	localparam cmd_t CMD_MEAS_MUL   = 5'd10;
	localparam cmd_t CMD_EST_SUM    = 5'd11;
	localparam cmd_t CMD_DIV_INIT   = 5'd12;
	localparam cmd_t CMD_DIV_STEP   = 5'd13;
	localparam cmd_t CMD_DIV_ADD    = 5'd14;
	localparam cmd_t CMD_SCAN_MATCH = 5'd15;
	localparam cmd_t CMD_EMIT       = 5'd16;

	// Status returned by the datapath to the controller.
	typedef struct packed {
		logic is_ack;
		logic scan_done;
		logic div_done;
		logic cut;
		logic grow_ok;
		logic matched;
		logic out_free;
	} status_t;

endpackage

[hdl/daw_ram.sv]
// Generic single-port-write, registered-read RAM.
module daw_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[hdl/daw_datapath.sv]
// Datapath: registers, shared multiplier, serial divider and pending table.
module daw_datapath import daw_pkg::*; #(
	parameter int TABLE_DEPTH = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cmd_t                 cmd,
	output status_t              status,
	input  logic                 in_op,
	input  logic [31:0]          in_seq,
	input  logic [31:0]          in_send_time,
	input  logic [31:0]          in_ack_time,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [15:0]          cfg_wdata,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [15:0]          out_window,
	output logic [31:0]          out_timeout,
	output logic                 out_window_cut,
	output logic                 out_ack_matched,
	output logic                 out_table_overflow
);

	localparam int IW = $clog2(TABLE_DEPTH);
	localparam logic [IW:0] DEPTH_CNT = (IW+1)'(TABLE_DEPTH);

	// Configuration registers.
	logic [15:0] gain_q, decr_q, incr_q, tgain_q;
	// Algorithm state.
	logic [31:0] cwnd_q;
	logic [39:0] est_q, min_q;
	logic [31:0] timeout_q;
	// Current item.
	logic        op_q;
	logic [31:0] seq_q, st_q;
	logic [39:0] meas_q;
	logic        dup_q, free_found_q, overflow_q, cut_q, matched_q, purge_q;
	logic [IW-1:0] free_q;
	logic [31:0] lim_q;
	// Arithmetic.
	logic [56:0] prod_q, acc_q;
	logic [32:0] rem_q;
	logic [39:0] dvd_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	// Table scan.
	logic [IW:0]   scan_idx_q;
	logic [IW-1:0] idx_s1;
	logic          vld_s1;
	logic [TABLE_DEPTH-1:0] valid_q;
	logic          out_valid_q;

	logic [39:0] mul_a;
	logic [16:0] mul_b;
	logic [56:0] mul_p;
	logic [63:0] rd_data;
	logic        ram_we;
	logic [31:0] e_time, e_seq;
	logic        e_valid, e_hit, e_old;
	logic        scanning;
	logic [32:0] div_sh;
	logic        div_ge;
	logic [40:0] grow_sum;
	logic [31:0] cut_win, to_sat;
	logic [57:0] est_sum;
	logic [31:0] meas_diff;

	// Operand selection for the shared multiplier.
	always_comb begin
		mul_a = min_q;
		mul_b = {1'b0, tgain_q};
		case (cmd)
			CMD_CUT_MUL: begin
				mul_a = {8'd0, cwnd_q};
				mul_b = {1'b0, decr_q};
			end
			CMD_EST_MUL: begin
				mul_a = est_q;
				mul_b = {1'b0, gain_q};
			end
			CMD_MEAS_MUL: begin
				mul_a = meas_q;
				mul_b = 17'h1_0000 - {1'b0, gain_q};
			end
			default: begin
				mul_a = min_q;
				mul_b = {1'b0, tgain_q};
			end
		endcase
	end
	assign mul_p = {17'd0, mul_a} * {40'd0, mul_b};

	// Derived values.
	assign to_sat    = (prod_q[56:48] != 9'd0) ? 32'hFFFF_FFFF : prod_q[47:16];
	assign cut_win   = (prod_q[47:16] < WINDOW_ONE) ? WINDOW_ONE : prod_q[47:16];
	assign est_sum   = {1'b0, acc_q} + {1'b0, prod_q};
	assign div_sh    = {rem_q[31:0], dvd_q[39]};
	assign div_ge    = div_sh >= {1'b0, cwnd_q};
	assign grow_sum  = {9'd0, cwnd_q} + {1'b0, dvd_q};
	assign meas_diff = in_ack_time - in_send_time;

	// Pending table entry under inspection.
	assign e_time  = rd_data[63:32];
	assign e_seq   = rd_data[31:0];
	assign e_valid = vld_s1 && valid_q[idx_s1];
	assign e_hit   = e_valid && e_time == st_q && e_seq == seq_q;
	assign e_old   = e_valid && (e_time < lim_q || (e_time == lim_q && e_seq == 32'd0));
	assign scanning = cmd == CMD_SCAN_DUP || cmd == CMD_SCAN_PURGE || cmd == CMD_SCAN_MATCH;
	assign ram_we   = cmd == CMD_INSERT && !dup_q && free_found_q;

	daw_ram #(.WIDTH(64), .DEPTH(TABLE_DEPTH)) u_pending (
		.clk   (clk),
		.we    (ram_we),
		.waddr (free_q),
		.wdata ({st_q, seq_q}),
		.raddr (scan_idx_q[IW-1:0]),
		.rdata (rd_data)
	);

	// Control registers: configuration, window, estimates, flags, valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q       <= RST_SMOOTHING_GAIN;
			decr_q       <= RST_DECREASE_FACTOR;
			incr_q       <= RST_INCREASE_STEP;
			tgain_q      <= RST_TIMEOUT_GAIN;
			cwnd_q       <= {RST_INITIAL_WINDOW, 16'd0};
			est_q        <= {16'd0, RST_INITIAL_RTT, 8'd0};
			min_q        <= {16'd0, RST_INITIAL_RTT, 8'd0};
			timeout_q    <= '0;
			valid_q      <= '0;
			scan_idx_q   <= '0;
			vld_s1       <= 1'b0;
			out_valid_q  <= 1'b0;
			dup_q        <= 1'b0;
			free_found_q <= 1'b0;
			overflow_q   <= 1'b0;
			cut_q        <= 1'b0;
			matched_q    <= 1'b0;
			purge_q      <= 1'b0;
			op_q         <= 1'b0;
			div_cnt_q    <= '0;
		end else begin
			// Configuration writes; the window and RTT loads follow the write.
			if (cfg_we) begin
				case (cfg_idx)
					REG_SMOOTHING_GAIN:  gain_q  <= cfg_wdata;
					REG_DECREASE_FACTOR: decr_q  <= cfg_wdata;
					REG_INCREASE_STEP:   incr_q  <= cfg_wdata;
					REG_TIMEOUT_GAIN:    tgain_q <= cfg_wdata;
					REG_INITIAL_WINDOW: begin
						cwnd_q <= (cfg_wdata == 16'd0) ? WINDOW_ONE : {cfg_wdata, 16'd0};
					end
					REG_INITIAL_RTT: begin
						est_q <= {16'd0, cfg_wdata, 8'd0};
						min_q <= {16'd0, cfg_wdata, 8'd0};
					end
					default: begin
					end
				endcase
			end

			// Scan address counter and its pipeline stage.
			if (scanning) begin
				if (scan_idx_q < DEPTH_CNT) begin
					scan_idx_q <= scan_idx_q + 1'b1;
					vld_s1     <= 1'b1;
				end else begin
					vld_s1 <= 1'b0;
				end
			end else begin
				scan_idx_q <= '0;
				vld_s1     <= 1'b0;
			end

			// Output register handshake.
			if (cmd == CMD_EMIT) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			case (cmd)
				CMD_LOAD: begin
					op_q         <= in_op;
					dup_q        <= 1'b0;
					free_found_q <= 1'b0;
					overflow_q   <= 1'b0;
					cut_q        <= 1'b0;
					matched_q    <= 1'b0;
					purge_q      <= 1'b0;
				end
				CMD_TO_SET: timeout_q <= to_sat;
				CMD_SCAN_DUP: begin
					if (e_hit) begin
						dup_q <= 1'b1;
					end
					if (vld_s1 && !valid_q[idx_s1] && !free_found_q) begin
						free_found_q <= 1'b1;
					end
				end
				CMD_INSERT: begin
					if (ram_we) begin
						valid_q[free_q] <= 1'b1;
					end
					overflow_q <= !dup_q && !free_found_q;
					purge_q    <= st_q > timeout_q;
				end
				CMD_SCAN_PURGE: begin
					if (purge_q && e_old) begin
						valid_q[idx_s1] <= 1'b0;
						cut_q <= 1'b1;
					end
				end
				CMD_CUT_SET: cwnd_q <= cut_win;
				CMD_EST_SUM: begin
					est_q <= est_sum[55:16];
					if (meas_q < min_q) begin
						min_q <= meas_q;
					end
				end
				CMD_DIV_INIT: div_cnt_q <= '0;
				CMD_DIV_STEP: div_cnt_q <= div_cnt_q + 1'b1;
				CMD_DIV_ADD: cwnd_q <= (grow_sum[40:32] != 9'd0) ? 32'hFFFF_FFFF : grow_sum[31:0];
				CMD_SCAN_MATCH: begin
					if (e_hit && !matched_q) begin
						valid_q[idx_s1] <= 1'b0;
						matched_q <= 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (scanning) begin
			idx_s1 <= scan_idx_q[IW-1:0];
		end
		case (cmd)
			CMD_LOAD: begin
				seq_q  <= in_seq;
				st_q   <= in_send_time;
				meas_q <= (in_ack_time >= in_send_time) ? {meas_diff, 8'd0} : 40'd0;
			end
			CMD_TO_MUL, CMD_CUT_MUL, CMD_EST_MUL: prod_q <= mul_p;
			CMD_MEAS_MUL: begin
				acc_q  <= prod_q;
				prod_q <= mul_p;
			end
			CMD_SCAN_DUP: begin
				if (vld_s1 && !valid_q[idx_s1] && !free_found_q) begin
					free_q <= idx_s1;
				end
			end
			CMD_INSERT: lim_q <= st_q - timeout_q;
			CMD_DIV_INIT: begin
				rem_q <= '0;
				dvd_q <= {incr_q, 24'd0};
			end
			CMD_DIV_STEP: begin
				rem_q <= div_ge ? div_sh - {1'b0, cwnd_q} : div_sh;
				dvd_q <= {dvd_q[38:0], div_ge};
			end
			CMD_EMIT: begin
				out_window         <= cwnd_q[31:16];
				out_timeout        <= timeout_q;
				out_window_cut     <= cut_q;
				out_ack_matched    <= matched_q;
				out_table_overflow <= overflow_q;
			end
			default: begin
			end
		endcase
	end

	// Status towards the controller.
	always_comb begin
		status.is_ack    = op_q;
		status.scan_done = scan_idx_q == DEPTH_CNT && !vld_s1;
		status.div_done  = div_cnt_q == DIV_CNT_W'(DIV_STEPS);
		status.cut       = cut_q;
		status.grow_ok   = {1'b0, est_q, 1'b0} < ({2'd0, min_q} + {1'b0, min_q, 1'b0});
		status.matched   = matched_q;
		status.out_free  = !out_valid_q || out_ready;
	end

	assign out_valid = out_valid_q;

endmodule

[hdl/daw_ctrl.sv]
// Controller state machine sequencing the datapath for one item at a time.
module daw_ctrl import daw_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  status_t status,
	output cmd_t    cmd
);

	localparam logic [4:0] S_IDLE       = 5'd0;
	localparam logic [4:0] S_ROUTE      = 5'd1;
	localparam logic [4:0] S_TO_MUL     = 5'd2;
	localparam logic [4:0] S_TO_SET     = 5'd3;
	localparam logic [4:0] S_SCAN_DUP   = 5'd4;
	localparam logic [4:0] S_INSERT     = 5'd5;
	localparam logic [4:0] S_PURGE      = 5'd6;
	localparam logic [4:0] S_CUT_MUL    = 5'd7;
	localparam logic [4:0] S_CUT_SET    = 5'd8;
	localparam logic [4:0] S_EST_MUL    = 5'd9;
	localparam logic [4:0] S_MEAS_MUL   = 5'd10;
	localparam logic [4:0] S_EST_SUM    = 5'd11;
	localparam logic [4:0] S_CMP        = 5'd12;
	localparam logic [4:0] S_DIV_INIT   = 5'd13;
	localparam logic [4:0] S_DIV_STEP   = 5'd14;
	localparam logic [4:0] S_DIV_ADD    = 5'd15;
	localparam logic [4:0] S_MATCH      = 5'd16;
	localparam logic [4:0] S_EMIT       = 5'd17;

	logic [4:0] state_q, state_d;
	logic       second_q, second_d;

	// Next state and command.
	always_comb begin
		state_d  = state_q;
		second_d = second_q;
		cmd      = CMD_NONE;
		case (state_q)
			S_IDLE: begin
				second_d = 1'b0;
				if (in_valid) begin
					cmd     = CMD_LOAD;
					state_d = S_ROUTE;
				end
			end
			S_ROUTE: state_d = status.is_ack ? S_EST_MUL : S_TO_MUL;
			S_TO_MUL: begin
				cmd     = CMD_TO_MUL;
				state_d = S_TO_SET;
			end
			S_TO_SET: begin
				cmd     = CMD_TO_SET;
				state_d = status.is_ack ? S_EMIT : S_SCAN_DUP;
			end
			S_SCAN_DUP: begin
				cmd = CMD_SCAN_DUP;
				if (status.scan_done) begin
					state_d = S_INSERT;
				end
			end
			S_INSERT: begin
				cmd     = CMD_INSERT;
				state_d = S_PURGE;
			end
			S_PURGE: begin
				cmd = CMD_SCAN_PURGE;
				if (status.scan_done) begin
					state_d = status.cut ? S_CUT_MUL : S_EMIT;
				end
			end
			S_CUT_MUL: begin
				cmd     = CMD_CUT_MUL;
				state_d = S_CUT_SET;
			end
			S_CUT_SET: begin
				cmd     = CMD_CUT_SET;
				state_d = S_EMIT;
			end
			S_EST_MUL: begin
				cmd     = CMD_EST_MUL;
				state_d = S_MEAS_MUL;
			end
			S_MEAS_MUL: begin
				cmd     = CMD_MEAS_MUL;
				state_d = S_EST_SUM;
			end
			S_EST_SUM: begin
				cmd     = CMD_EST_SUM;
				state_d = S_CMP;
			end
			S_CMP: state_d = status.grow_ok ? S_DIV_INIT : S_MATCH;
			S_DIV_INIT: begin
				cmd     = CMD_DIV_INIT;
				state_d = S_DIV_STEP;
			end
			S_DIV_STEP: begin
				if (status.div_done) begin
					state_d = S_DIV_ADD;
				end else begin
					cmd = CMD_DIV_STEP;
				end
			end
			S_DIV_ADD: begin
				cmd     = CMD_DIV_ADD;
				state_d = second_q ? S_TO_MUL : S_MATCH;
			end
			S_MATCH: begin
				cmd = CMD_SCAN_MATCH;
				if (status.scan_done) begin
					if (status.matched) begin
						second_d = 1'b1;
						state_d  = S_DIV_INIT;
					end else begin
						state_d = S_TO_MUL;
					end
				end
			end
			S_EMIT: begin
				if (status.out_free) begin
					cmd     = CMD_EMIT;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// State registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			second_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			second_q <= second_d;
		end
	end

	assign in_ready = state_q == S_IDLE;

endmodule

[hdl/delay_aimd_congestion_window_unit.sv]
// A sent item makes two passes over the pending table, plus a multiply and a set when the window is cut.
// An ack makes one pass over the table, plus a division for each window increase (40-step divider).
// One item is in work at a time; the next is taken once the result sits in the output register.
// Reset clears the pending valid bits at once and loads window, RTT estimate and minimum
// from the register reset values; no clearing pass is needed.
module delay_aimd_congestion_window_unit import daw_pkg::*; #(
	parameter int TABLE_DEPTH = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 op,
	input  logic [31:0]          seq,
	input  logic [31:0]          send_time,
	input  logic [31:0]          ack_time,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [15:0]          window,
	output logic [31:0]          timeout,
	output logic                 window_cut,
	output logic                 ack_matched,
	output logic                 table_overflow,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]          cfg_data
);

	cmd_t    cmd;
	status_t status;

	// Register writes are always taken.
	assign cfg_ready = 1'b1;

	daw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	daw_datapath #(.TABLE_DEPTH(TABLE_DEPTH)) u_datapath (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.status             (status),
		.in_op              (op),
		.in_seq             (seq),
		.in_send_time       (send_time),
		.in_ack_time        (ack_time),
		.cfg_we             (cfg_valid),
		.cfg_idx            (cfg_index),
		.cfg_wdata          (cfg_data),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.out_window         (window),
		.out_timeout        (timeout),
		.out_window_cut     (window_cut),
		.out_ack_matched    (ack_matched),
		.out_table_overflow (table_overflow)
	);

endmodule

[hdl/daw_checker.sv]
// Port-level checker of the congestion window unit, bound to the top level.
`include "delay_aimd_congestion_window_unit_assert.svh"

module daw_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] window,
	input logic        window_cut,
	input logic        ack_matched
);

	// A result waiting for transfer stays, with its window unchanged.
	`DAW_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(window), "result dropped or changed while stalled")
	// The window never reports less than one datagram.
	`DAW_ASSERT(a_window_nonzero, out_valid |-> window != 16'd0, "window below one datagram")
	// One item at a time: after an input transfer the unit is busy.
	`DAW_ASSERT(a_one_item, in_valid && in_ready |=> !in_ready, "second item taken while busy")
	// A cut belongs to a sent item and a match to an ack, never both.
	`DAW_ASSERT(a_flag_excl, out_valid |-> !(window_cut && ack_matched), "cut and match in one result")

endmodule

bind delay_aimd_congestion_window_unit daw_checker u_daw_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.window      (window),
	.window_cut  (window_cut),
	.ack_matched (ack_matched)
);

[verif/tb.sv]
// Self-checking testbench of the delay-based AIMD congestion window unit.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import daw_pkg::*;

	localparam int DEPTH = 64;
	localparam longint CYCLE_LIMIT = 3000000;
	localparam bit [63:0] Q16_ONE = 64'h1_0000;
	localparam bit [63:0] W_MAX = 64'hFFFF_FFFF;
	localparam bit [63:0] MASK40 = 64'hFF_FFFF_FFFF;

	typedef struct packed {
		logic        op;
		logic [31:0] seq;
		logic [31:0] send_time;
		logic [31:0] ack_time;
	} packet_t;

	typedef struct packed {
		logic [15:0] window;
		logic [31:0] timeout;
		logic        window_cut;
		logic        ack_matched;
		logic        table_overflow;
	} window_report_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic op = 1'b0;
	logic [31:0] seq = '0;
	logic [31:0] send_time = '0;
	logic [31:0] ack_time = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [15:0] window;
	logic [31:0] timeout;
	logic window_cut;
	logic ack_matched;
	logic table_overflow;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;

	delay_aimd_congestion_window_unit i_dut (.*);

	always #4 clk = ~clk;

	// Shadow registers and state of the window controller.
	bit [63:0] gain_smooth, gain_decrease, step_increase, gain_timeout;
	bit [63:0] win_q16, rtt_est, rtt_min;
	bit        slot_used [DEPTH];
	bit [31:0] slot_time [DEPTH];
	bit [31:0] slot_seq [DEPTH];

	packet_t        packets_pending[$];
	window_report_t window_reports[$];
	bit [31:0]      sent_times[$];
	bit [31:0]      sent_seqs[$];
	int             send_idle_pct = 0;
	int             recv_stall_pct = 0;
	int             error_count = 0;
	int             reports_seen = 0;
	int             cuts_seen = 0, matches_seen = 0, overflows_seen = 0;
	longint         cycle_count = 0;

	function automatic void set_window(bit [63:0] w);
		if (w < Q16_ONE)
			w = Q16_ONE;
		if (w > W_MAX)
			w = W_MAX;
		win_q16 = w;
	endfunction

	function automatic bit [63:0] predicted_timeout();
		bit [63:0] t;
		t = (rtt_min * gain_timeout) >> 16;
		return (t > W_MAX) ? W_MAX : t;
	endfunction

	function automatic void grow_window();
		bit [63:0] d;
		d = win_q16 ? win_q16 : Q16_ONE;
		set_window(win_q16 + ((step_increase << 24) / d));
	endfunction

	function automatic void load_register(logic [CFG_IDX_W-1:0] idx, logic [15:0] v);
		case (idx)
			REG_SMOOTHING_GAIN: gain_smooth = v;
			REG_DECREASE_FACTOR: gain_decrease = v;
			REG_INCREASE_STEP: step_increase = v;
			REG_TIMEOUT_GAIN: gain_timeout = v;
			REG_INITIAL_WINDOW: set_window(64'(v) << 16);
			REG_INITIAL_RTT: begin
				rtt_est = 64'(v) << 8;
				rtt_min = 64'(v) << 8;
			end
			default: ;
		endcase
	endfunction

	// Advances the window state by one packet and returns the report it yields.
	function automatic window_report_t update_window(packet_t p);
		window_report_t r;
		bit [63:0] to, lim, meas, to_now;
		int free_slot;
		bit dup;
		r = '0;
		free_slot = -1;
		dup = 1'b0;
		if (!p.op) begin
			to = predicted_timeout();
			for (int i = 0; i < DEPTH; i++) begin
				if (slot_used[i]) begin
					if (slot_time[i] == p.send_time && slot_seq[i] == p.seq)
						dup = 1'b1;
				end else if (free_slot < 0) begin
					free_slot = i;
				end
			end
			if (!dup) begin
				if (free_slot >= 0) begin
					slot_used[free_slot] = 1'b1;
					slot_time[free_slot] = p.send_time;
					slot_seq[free_slot] = p.seq;
				end else begin
					r.table_overflow = 1'b1;
				end
			end
			// Purge entries older than the timeout and cut once if any went.
			if (64'(p.send_time) > to) begin
				lim = 64'(p.send_time) - to;
				for (int i = 0; i < DEPTH; i++) begin
					if (slot_used[i] && (64'(slot_time[i]) < lim ||
						(64'(slot_time[i]) == lim && slot_seq[i] == 0))) begin
						slot_used[i] = 1'b0;
						r.window_cut = 1'b1;
					end
				end
				if (r.window_cut)
					set_window((win_q16 * gain_decrease) >> 16);
			end
		end else begin
			meas = (p.ack_time >= p.send_time) ? (64'(p.ack_time - p.send_time) << 8) : 0;
			rtt_est = ((gain_smooth * rtt_est + (64'd65536 - gain_smooth) * meas) >> 16)
				& MASK40;
			if (meas < rtt_min)
				rtt_min = meas;
			if (2 * rtt_est < 3 * rtt_min)
				grow_window();
			for (int i = 0; i < DEPTH; i++) begin
				if (!r.ack_matched && slot_used[i] && slot_time[i] == p.send_time &&
					slot_seq[i] == p.seq) begin
					slot_used[i] = 1'b0;
					r.ack_matched = 1'b1;
				end
			end
			if (r.ack_matched)
				grow_window();
		end
		to_now = predicted_timeout();
		r.window = win_q16[31:16];
		r.timeout = to_now[31:0];
		return r;
	endfunction

	// Driver: presents queued packets and predicts each one on its transfer.
	always @(posedge clk) begin
		packet_t p;
		if (arst_n) begin
			if (in_valid && in_ready)
				window_reports.push_back(update_window({op, seq, send_time, ack_time}));
			if (!in_valid || in_ready) begin
				if (packets_pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					p = packets_pending.pop_front();
					op <= p.op;
					seq <= p.seq;
					send_time <= p.send_time;
					ack_time <= p.ack_time;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks every result transfer against the oldest prediction.
	always @(posedge clk) begin
		window_report_t e;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				reports_seen++;
				if (window_reports.size() == 0) begin
					$error("result with no prediction pending");
					error_count++;
				end else begin
					e = window_reports.pop_front();
					cuts_seen += e.window_cut;
					matches_seen += e.ack_matched;
					overflows_seen += e.table_overflow;
					if (window !== e.window) begin
						$error("window: expected %0d, got %0d", e.window, window);
						error_count++;
					end
					if (timeout !== e.timeout) begin
						$error("timeout: expected %0d, got %0d", e.timeout, timeout);
						error_count++;
					end
					if (window_cut !== e.window_cut) begin
						$error("window_cut: expected %0d, got %0d", e.window_cut, window_cut);
						error_count++;
					end
					if (ack_matched !== e.ack_matched) begin
						$error("ack_matched: expected %0d, got %0d", e.ack_matched,
							ack_matched);
						error_count++;
					end
					if (table_overflow !== e.table_overflow) begin
						$error("table_overflow: expected %0d, got %0d", e.table_overflow,
							table_overflow);
						error_count++;
					end
				end
			end
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Watchdog on the cycle count.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb: done, errors");
			$finish;
		end
	end

	task automatic queue_packet(logic o, logic [31:0] s, logic [31:0] st, logic [31:0] at);
		packets_pending.push_back({o, s, st, at});
		if (!o) begin
			sent_times.push_back(st);
			sent_seqs.push_back(s);
			if (sent_times.size() > 128) begin
				void'(sent_times.pop_front());
				void'(sent_seqs.pop_front());
			end
		end
	endtask

	task automatic wait_drained();
		while (packets_pending.size() > 0 || in_valid) @(posedge clk);
	endtask

	// Holds the sender until every predicted result has arrived.
	task automatic wait_idle();
		wait_drained();
		while (window_reports.size() > 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic write_registers(logic [15:0] v [6], bit with_unused);
		int n;
		n = with_unused ? 8 : 6;
		for (int i = 0; i < n; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= CFG_IDX_W'(i);
			cfg_data <= (i < 6) ? v[i] : 16'($urandom);
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
			load_register(CFG_IDX_W'(i), (i < 6) ? v[i] : 16'h0);
		end
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Mostly well-formed sends and matching acks, with some noise mixed in.
	task automatic queue_traffic(int count, int step_ms, int rtt_ms);
		bit [31:0] now;
		bit [31:0] s;
		int k, pick;
		now = sent_times.size() ? sent_times[$] : 32'($urandom_range(5000));
		s = sent_seqs.size() ? sent_seqs[$] : 0;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(99);
			if (pick < 45) begin
				now += (pick < 3) ? $urandom_range(20 * step_ms) : $urandom_range(step_ms);
				if (pick < 5 && sent_times.size() > 0) begin
					k = $urandom_range(sent_times.size() - 1);
					queue_packet(1'b0, sent_seqs[k], sent_times[k], 32'($urandom));
				end else begin
					s = (pick < 10) ? 32'($urandom) : s + 1;
					queue_packet(1'b0, s, now, 32'($urandom));
				end
			end else if (pick < 85 && sent_times.size() > 0) begin
				k = $urandom_range(sent_times.size() - 1);
				queue_packet(1'b1, sent_seqs[k], sent_times[k],
					(pick < 80) ? sent_times[k] + $urandom_range(rtt_ms) : 32'($urandom));
			end else begin
				queue_packet(1'($urandom), 32'($urandom), 32'($urandom), 32'($urandom));
			end
		end
	endtask

	// Runs traffic in chunks, each under one of the idling patterns.
	task automatic run_phase(int count, int step_ms, int rtt_ms);
		for (int c = 0; c < count; c += 50) begin
			case ((c / 50) % 4)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 86; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 86; end
				default: begin send_idle_pct = 33; recv_stall_pct = 33; end
			endcase
			queue_traffic((count - c < 50) ? count - c : 50, step_ms, rtt_ms);
			wait_drained();
		end
		wait_idle();
	endtask

	initial begin
		logic [15:0] regs [6];
		gain_smooth = RST_SMOOTHING_GAIN;
		gain_decrease = RST_DECREASE_FACTOR;
		step_increase = RST_INCREASE_STEP;
		gain_timeout = RST_TIMEOUT_GAIN;
		set_window(64'(RST_INITIAL_WINDOW) << 16);
		rtt_est = 64'(RST_INITIAL_RTT) << 8;
		rtt_min = 64'(RST_INITIAL_RTT) << 8;
		for (int i = 0; i < DEPTH; i++)
			slot_used[i] = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: duplicate send, purge on the equal-time seq-zero boundary,
		// ack before send, zero timeout and field extremes.
		queue_packet(1'b0, 32'd0, 32'd1000, 32'd0);
		queue_packet(1'b0, 32'd0, 32'd1000, 32'hFFFF_FFFF);
		queue_packet(1'b0, 32'hFFFF_FFFF, 32'd1000, 32'd0);
		queue_packet(1'b0, 32'd3, 32'd1001, 32'd0);
		queue_packet(1'b0, 32'd9, 32'd1200, 32'd0);
		queue_packet(1'b0, 32'd1, 32'd0, 32'd0);
		queue_packet(1'b1, 32'hFFFF_FFFF, 32'd1000, 32'd1050);
		queue_packet(1'b1, 32'd3, 32'd1001, 32'd0);
		queue_packet(1'b0, 32'd4, 32'hFFFF_FFFF, 32'd0);
		queue_packet(1'b1, 32'd4, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		queue_packet(1'b1, 32'd0, 32'd0, 32'hFFFF_FFFF);
		queue_packet(1'b1, 32'h5555_AAAA, 32'hAAAA_5555, 32'h5555_AAAA);
		queue_packet(1'b0, 32'd0, 32'd0, 32'hFFFF_FFFF);
		queue_packet(1'b1, 32'd1, 32'd0, 32'd0);
		wait_idle();

		sent_times.delete();
		sent_seqs.delete();
		run_phase(250, 30, 300);

		// Extremes high: huge timeout, so a burst of sends fills the table.
		regs = '{16'd0, 16'd0, 16'd65535, 16'd65535, 16'd65535, 16'd65535};
		write_registers(regs, 1'b0);
		for (int i = 0; i < 72; i++)
			queue_packet(1'b0, 32'(i), 32'(5000 + i), 32'($urandom));
		wait_idle();
		run_phase(150, 50, 2000);

		// Extremes low: zero timeout purges on almost every send.
		regs = '{16'd65535, 16'd65535, 16'd0, 16'd0, 16'd1, 16'd0};
		write_registers(regs, 1'b0);
		run_phase(200, 10, 100);

		regs = '{16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom_range(2048)),
			16'($urandom_range(1, 65535)), 16'($urandom_range(400))};
		write_registers(regs, 1'b0);
		run_phase(200, 40, 400);

		regs = '{16'd30000, 16'd50000, 16'd1000, 16'd300, 16'd20, 16'd40};
		write_registers(regs, 1'b1);
		run_phase(200, 20, 80);

		$display("tb: %0d results checked, %0d cuts, %0d acks matched, %0d overflows",
			reports_seen, cuts_seen, matches_seen, overflows_seen);
		$display("tb: five register settings including both extremes, four idling patterns");
		if (error_count == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end
endmodule
